/* hdl/pidc_pkg.sv */
`default_nettype none
package pidc_pkg;

    localparam int DW    = 32;
    localparam int FB    = 16;
    localparam int PW    = 2 * DW;
    localparam int EW    = DW + 3;
    localparam int CNT_W = $clog2(PW);
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_P_GAIN      = 3'd0;
    localparam logic [IDX_W-1:0] REG_I_GAIN      = 3'd1;
    localparam logic [IDX_W-1:0] REG_D_GAIN      = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOWER_BOUND = 3'd3;
    localparam logic [IDX_W-1:0] REG_UPPER_BOUND = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEAD_BAND   = 3'd5;
    localparam logic [IDX_W-1:0] REG_DERIVE_MEAS = 3'd6;
    localparam logic [IDX_W-1:0] REG_BACK_CALC   = 3'd7;

    localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
        return x[DW-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [EW-1:0] ext(input logic [DW-1:0] x);
        return {{(EW-DW){x[DW-1]}}, x};
    endfunction

    function automatic logic [DW-1:0] sat(input logic [EW-1:0] x);
        logic fits;
        fits = (x[EW-1:DW-1] == {(EW-DW+1){1'b0}}) || (x[EW-1:DW-1] == {(EW-DW+1){1'b1}});
        if (fits) begin
            return x[DW-1:0];
        end
        return x[EW-1] ? DMIN : DMAX;
    endfunction

    function automatic logic [DW-1:0] sat_mag(input logic [PW-1:0] q, input logic neg);
        logic [PW-1:0] cap;
        logic [PW-1:0] v;
        cap = neg ? {{(PW-DW){1'b0}}, DMIN} : {{(PW-DW){1'b0}}, DMAX};
        v = (q > cap) ? cap : q;
        return neg ? (~v[DW-1:0] + 1'b1) : v[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] scale_fin(input logic [PW-1:0] p, input logic neg);
        return sat_mag(p >> FB, neg);
    endfunction

endpackage
`default_nettype wire

/* hdl/pid_controller_step_top.sv */
`default_nettype none
// Channel   Direction  Ports                                         Transfer
// s_        in         s_mode s_target s_measured s_feed_forward     s_valid & s_ready
//                      s_elapsed
// m_        out        m_drive                                       m_valid & m_ready
// cfg_      in         cfg_index cfg_data                            cfg_valid & cfg_ready
//
// A compute item passes through the serial divider, which is skipped with zero
// elapsed. A clear item zeroes the stored state and gives no result.
// One shared 32x32 multiplier and a one-bit-per-cycle divider do the arithmetic.
// Reset is synchronous, active low; configuration is accepted every cycle.
// The next item is accepted while the result waits in the output register.
module pid_controller_step_top
    import pidc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_mode,
    input  wire logic [DW-1:0]    s_target,
    input  wire logic [DW-1:0]    s_measured,
    input  wire logic [DW-1:0]    s_feed_forward,
    input  wire logic [DW-1:0]    s_elapsed,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [DW-1:0]         m_drive,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [DW-1:0]    cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ERR, ST_DBAND, ST_MUL_P, ST_FIN_P, ST_MUL_I1, ST_FIN_I1,
        ST_MUL_I2, ST_FIN_I2, ST_ACC_I, ST_DELTA, ST_MUL_D, ST_DIV_GO, ST_DIV_WAIT,
        ST_SUM1, ST_SUM2, ST_SUM3, ST_CLAMP, ST_BACK, ST_OUTPUT
    } state_t;

    state_t state_reg;

    logic [DW-1:0] p_gain_reg, i_gain_reg, d_gain_reg, lower_reg, upper_reg;
    logic [DW-2:0] dead_band_reg;
    logic          derive_meas_reg, back_calc_reg;

    logic [DW-1:0] integ_reg, last_err_reg, last_meas_reg;
    logic [DW-1:0] target_reg, meas_reg, ff_reg, dt_reg;
    logic [DW-1:0] err_reg, pterm_reg, term_reg, delta_reg, dterm_reg, drive_reg;
    logic [EW-1:0] sum_reg, excess_reg;
    logic          adjust_reg, dneg_reg;
    logic          m_valid_reg;
    logic [DW-1:0] m_drive_reg;

    logic [DW-1:0] mul_a, mul_b;
    logic          mul_neg;
    logic [PW-1:0] prod_reg;
    logic          neg_reg;

    logic          div_start, div_done;
    logic [PW-1:0] div_quot;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (state_reg)
            ST_MUL_P: begin
                mul_a   = mag(err_reg);
                mul_b   = mag(p_gain_reg);
                mul_neg = err_reg[DW-1] ^ p_gain_reg[DW-1];
            end
            ST_MUL_I1: begin
                mul_a   = mag(err_reg);
                mul_b   = dt_reg;
                mul_neg = err_reg[DW-1];
            end
            ST_MUL_I2: begin
                mul_a   = mag(term_reg);
                mul_b   = mag(i_gain_reg);
                mul_neg = term_reg[DW-1] ^ i_gain_reg[DW-1];
            end
            ST_MUL_D: begin
                mul_a   = mag(d_gain_reg);
                mul_b   = mag(delta_reg);
                mul_neg = d_gain_reg[DW-1] ^ delta_reg[DW-1];
            end
            default: begin
                mul_a   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        neg_reg  <= mul_neg;
    end

    assign div_start = (state_reg == ST_DIV_GO) && (dt_reg != '0);

    pidc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg      <= '0;
            i_gain_reg      <= '0;
            d_gain_reg      <= '0;
            lower_reg       <= DMIN;
            upper_reg       <= DMAX;
            dead_band_reg   <= '0;
            derive_meas_reg <= 1'b0;
            back_calc_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_P_GAIN:      p_gain_reg      <= cfg_data;
                REG_I_GAIN:      i_gain_reg      <= cfg_data;
                REG_D_GAIN:      d_gain_reg      <= cfg_data;
                REG_LOWER_BOUND: lower_reg       <= cfg_data;
                REG_UPPER_BOUND: upper_reg       <= cfg_data;
                REG_DEAD_BAND:   dead_band_reg   <= cfg_data[DW-2:0];
                REG_DERIVE_MEAS: derive_meas_reg <= cfg_data[0];
                REG_BACK_CALC:   back_calc_reg   <= cfg_data[0];
                default:         back_calc_reg   <= back_calc_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            last_meas_reg <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUTPUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_mode) begin
                            integ_reg     <= '0;
                            last_err_reg  <= '0;
                            last_meas_reg <= '0;
                        end else begin
                            target_reg <= s_target;
                            meas_reg   <= s_measured;
                            ff_reg     <= s_feed_forward;
                            dt_reg     <= s_elapsed;
                            state_reg  <= ST_ERR;
                        end
                    end
                end
                ST_ERR: begin
                    err_reg   <= sat(ext(target_reg) - ext(meas_reg));
                    state_reg <= ST_DBAND;
                end
                ST_DBAND: begin
                    if (mag(err_reg) < {1'b0, dead_band_reg}) begin
                        err_reg <= '0;
                    end
                    state_reg <= ST_MUL_P;
                end
                ST_MUL_P:  state_reg <= ST_FIN_P;
                ST_FIN_P: begin
                    pterm_reg <= scale_fin(prod_reg, neg_reg);
                    state_reg <= ST_MUL_I1;
                end
                ST_MUL_I1: state_reg <= ST_FIN_I1;
                ST_FIN_I1: begin
                    term_reg  <= scale_fin(prod_reg, neg_reg);
                    state_reg <= ST_MUL_I2;
                end
                ST_MUL_I2: state_reg <= ST_FIN_I2;
                ST_FIN_I2: begin
                    term_reg  <= scale_fin(prod_reg, neg_reg);
                    state_reg <= ST_ACC_I;
                end
                ST_ACC_I: begin
                    integ_reg <= sat(ext(integ_reg) + ext(term_reg));
                    state_reg <= ST_DELTA;
                end
                ST_DELTA: begin
                    delta_reg <= derive_meas_reg ? sat(ext(meas_reg) - ext(last_meas_reg))
                                                 : sat(ext(err_reg) - ext(last_err_reg));
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D:  state_reg <= ST_DIV_GO;
                ST_DIV_GO: begin
                    dneg_reg  <= neg_reg;
                    dterm_reg <= '0;
                    state_reg <= (dt_reg == '0) ? ST_SUM1 : ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        dterm_reg <= sat_mag(div_quot, dneg_reg);
                        state_reg <= ST_SUM1;
                    end
                end
                ST_SUM1: begin
                    sum_reg   <= ext(ff_reg) + ext(pterm_reg);
                    state_reg <= ST_SUM2;
                end
                ST_SUM2: begin
                    sum_reg   <= sum_reg + ext(integ_reg);
                    state_reg <= ST_SUM3;
                end
                ST_SUM3: begin
                    sum_reg   <= sum_reg + ext(dterm_reg);
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    if ($signed(sum_reg) > $signed(ext(upper_reg))) begin
                        drive_reg  <= upper_reg;
                        excess_reg <= sum_reg - ext(upper_reg);
                        adjust_reg <= back_calc_reg;
                    end else if ($signed(sum_reg) < $signed(ext(lower_reg))) begin
                        drive_reg  <= lower_reg;
                        excess_reg <= sum_reg - ext(lower_reg);
                        adjust_reg <= back_calc_reg;
                    end else begin
                        drive_reg  <= sum_reg[DW-1:0];
                        excess_reg <= '0;
                        adjust_reg <= 1'b0;
                    end
                    state_reg <= ST_BACK;
                end
                ST_BACK: begin
                    if (adjust_reg) begin
                        integ_reg <= sat(ext(integ_reg) - excess_reg);
                    end
                    last_err_reg  <= err_reg;
                    last_meas_reg <= meas_reg;
                    state_reg     <= ST_OUTPUT;
                end
                ST_OUTPUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_drive_reg <= drive_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_drive   = m_drive_reg;

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode |=> integ_reg == '0 && last_err_reg == '0
            && last_meas_reg == '0 && state_reg == ST_IDLE)
        else $error("clear transfer did not zero state");

    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode |=> !s_ready)
        else $error("ready after compute transfer");

    a_drive_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ($signed(lower_reg) <= $signed(upper_reg))
            |-> ($signed(m_drive) >= $signed(lower_reg))
             && ($signed(m_drive) <= $signed(upper_reg)))
        else $error("drive outside bounds");

    a_div_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside wait state");

endmodule
`default_nettype wire

/* hdl/pidc_div.sv */
`default_nettype none
module pidc_div
    import pidc_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [PW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic [PW-1:0]      quotient
);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [PW-1:0]    dvd_reg;
    logic [DW-1:0]    dsr_reg;
    logic [DW:0]      shifted;
    logic             fits;

    assign shifted = {rem_reg, dvd_reg[PW-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= '0;
                dvd_reg <= dividend;
                dsr_reg <= divisor;
            end else if (run_reg) begin
                rem_reg <= fits ? DW'(shifted - {1'b0, dsr_reg}) : shifted[DW-1:0];
                dvd_reg <= {dvd_reg[PW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PW - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire
